// ===== src/grfr_pkg.sv =====
// Shared types, constants and helpers for the gradient rectangle fill engine.
// No dependencies; imported by every module of the block.
package grfr_pkg;

    // Dimension limits
    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int CNT_W     = $clog2(MAX_DIM);

    // Color and address widths
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int COLOR_W   = CH_W * NUM_CH;
    localparam int ADDR_W    = 24;

    // Gradient divider: quotient never exceeds one channel, so one step per quotient bit
    localparam int PROD_W    = CH_W + CNT_W;
    localparam int DIV_STEPS = CH_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Configuration port
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = COLOR_W;

    localparam logic [REG_IDX_W-1:0] REG_FB_COLS      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_FB_ROWS      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RECT_LEFT    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RECT_TOP     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RECT_WIDTH   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RECT_HEIGHT  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_TOP    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_BOTTOM = 3'd7;

    typedef struct packed {
        logic [DIM_W-1:0]   fb_cols;
        logic [DIM_W-1:0]   fb_rows;
        logic [DIM_W-1:0]   rect_left;
        logic [DIM_W-1:0]   rect_top;
        logic [DIM_W-1:0]   rect_width;
        logic [DIM_W-1:0]   rect_height;
        logic [COLOR_W-1:0] color_top;
        logic [COLOR_W-1:0] color_bottom;
    } cfg_t;

    // Controller to datapath
    typedef struct packed {
        logic take;        // input transfer this cycle
        logic mul_load;    // form channel products, load divider
        logic div_step;    // one restoring divide step
        logic color_load;  // commit new row color
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic row_adv;     // accepted pixel moves the walk to a new row
    } sts_t;

    // Dimensions above the limit count as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

endpackage

// ===== src/gradient_rect_fill_raster_top.sv =====
// Top level of the gradient rectangle fill engine.
// Depends on grfr_pkg, grfr_cfg_regs, grfr_ctrl and grfr_datapath.

// Each input transfer walks one pixel of the rectangle in raster order and yields
// one result: write enable, framebuffer word address, row color and pass-done.
// A pixel that stays within its row needs no color update, so a row streams at one
// pixel per clock while the output is taken. The last pixel of a row that continues
// into another row holds off the next transfer while the new row color is formed:
// the channel products, eight steps of the restoring divider that computes the new
// row color, and a commit, after which its result is shown. An idle tick and the
// last pixel of a pass skip this sequence; a restart counts as the first pixel of
// its pass. Registers are written through cfg_we/cfg_index/cfg_wdata and take
// effect on the next transfer.
module gradient_rect_fill_raster_top import grfr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_restart,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_write_enable,
    output logic [ADDR_W-1:0]     m_pixel_address,
    output logic [COLOR_W-1:0]    m_pixel_color,
    output logic                  m_pass_done
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    // Configuration registers
    grfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Sequencer and handshakes
    grfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Walk, address and color datapath
    grfr_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .cmd             (cmd),
        .sts             (sts),
        .s_restart       (s_restart),
        .m_write_enable  (m_write_enable),
        .m_pixel_address (m_pixel_address),
        .m_pixel_color   (m_pixel_color),
        .m_pass_done     (m_pass_done)
    );

endmodule

// ===== src/grfr_cfg_regs.sv =====
// Configuration register file of the fill engine.
// Depends on grfr_pkg.
module grfr_cfg_regs import grfr_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    // Register writes, all clear to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_FB_COLS:      cfg_reg.fb_cols      <= cfg_wdata[DIM_W-1:0];
                REG_FB_ROWS:      cfg_reg.fb_rows      <= cfg_wdata[DIM_W-1:0];
                REG_RECT_LEFT:    cfg_reg.rect_left    <= cfg_wdata[DIM_W-1:0];
                REG_RECT_TOP:     cfg_reg.rect_top     <= cfg_wdata[DIM_W-1:0];
                REG_RECT_WIDTH:   cfg_reg.rect_width   <= cfg_wdata[DIM_W-1:0];
                REG_RECT_HEIGHT:  cfg_reg.rect_height  <= cfg_wdata[DIM_W-1:0];
                REG_COLOR_TOP:    cfg_reg.color_top    <= cfg_wdata[COLOR_W-1:0];
                REG_COLOR_BOTTOM: cfg_reg.color_bottom <= cfg_wdata[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/grfr_datapath.sv =====
// Datapath: walk counters, clipping, address MAC, result register and the
// three-lane row color divider. Depends on grfr_pkg.
module grfr_datapath import grfr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic               s_restart,
    output logic               m_write_enable,
    output logic [ADDR_W-1:0]  m_pixel_address,
    output logic [COLOR_W-1:0] m_pixel_color,
    output logic               m_pass_done
);

    // Walk state
    logic [CNT_W-1:0]   col_reg, row_reg;
    logic               active_reg;
    logic [COLOR_W-1:0] color_reg;

    // Result register
    logic               we_reg, done_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [COLOR_W-1:0] pcolor_reg;

    // Divider lanes
    logic [DIM_W-1:0]   rem_reg  [NUM_CH];
    logic [CH_W-1:0]    low_reg  [NUM_CH];
    logic [CH_W-1:0]    quot_reg [NUM_CH];

    logic [DIM_W-1:0]   w_clamp, h_clamp;
    logic [CNT_W-1:0]   col_e, row_e;
    logic               active_e;
    logic [COLOR_W-1:0] color_e;
    logic [DIM_W-1:0]   col_inc, row_inc;
    logic               row_end, pass_end;
    logic signed [DIM_W:0] px, py;
    logic               visible;
    logic [2*DIM_W-1:0] addr_full;

    logic [CH_W-1:0]    ch_top  [NUM_CH];
    logic [CH_W-1:0]    ch_bot  [NUM_CH];
    logic               ch_up   [NUM_CH];
    logic [CH_W-1:0]    ch_diff [NUM_CH];
    logic [PROD_W-1:0]  ch_prod [NUM_CH];
    logic [DIM_W:0]     trial   [NUM_CH];
    logic               fits    [NUM_CH];
    logic [COLOR_W-1:0] grad_color;

    assign w_clamp = clamp_dim(cfg.rect_width);
    assign h_clamp = clamp_dim(cfg.rect_height);

    // Restart puts the walk at the top-left with the top color
    assign col_e    = s_restart ? '0 : col_reg;
    assign row_e    = s_restart ? '0 : row_reg;
    assign active_e = s_restart ? ((w_clamp != '0) && (h_clamp != '0)) : active_reg;
    assign color_e  = s_restart ? cfg.color_top : color_reg;

    // End of row / end of pass
    assign col_inc  = {1'b0, col_e} + DIM_W'(1);
    assign row_inc  = {1'b0, row_e} + DIM_W'(1);
    assign row_end  = (col_inc >= w_clamp);
    assign pass_end = row_end && (row_inc >= h_clamp);

    assign sts.row_adv = active_e && row_end && !pass_end;

    // Pixel position; negative values fall outside by the sign bit
    assign px = $signed({cfg.rect_left[DIM_W-1], cfg.rect_left}) + $signed({2'b00, col_e});
    assign py = $signed({cfg.rect_top[DIM_W-1], cfg.rect_top}) + $signed({2'b00, row_e});
    assign visible = !px[DIM_W] && (px[DIM_W-1:0] < cfg.fb_cols)
                  && !py[DIM_W] && (py[DIM_W-1:0] < cfg.fb_rows);

    // Row times pitch plus column, low bits kept
    assign addr_full = py[DIM_W-1:0] * cfg.fb_cols + (2*DIM_W)'(px[DIM_W-1:0]);

    // Per-channel difference, direction and product
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            ch_top[i]  = cfg.color_top[i*CH_W +: CH_W];
            ch_bot[i]  = cfg.color_bottom[i*CH_W +: CH_W];
            ch_up[i]   = (ch_bot[i] >= ch_top[i]);
            ch_diff[i] = ch_up[i] ? (ch_bot[i] - ch_top[i]) : (ch_top[i] - ch_bot[i]);
            ch_prod[i] = ch_diff[i] * row_reg;
            trial[i]   = {rem_reg[i], low_reg[i][CH_W-1]};
            fits[i]    = (trial[i] >= {1'b0, h_clamp});
            grad_color[i*CH_W +: CH_W] = ch_up[i] ? (ch_top[i] + quot_reg[i])
                                                   : (ch_top[i] - quot_reg[i]);
        end
    end

    // Walk state and row color
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg    <= '0;
            row_reg    <= '0;
            active_reg <= 1'b0;
            color_reg  <= '0;
        end else if (cmd.take) begin
            color_reg <= color_e;
            if (!active_e) begin
                col_reg    <= col_e;
                row_reg    <= row_e;
                active_reg <= 1'b0;
            end else if (row_end) begin
                col_reg <= '0;
                if (pass_end) begin
                    row_reg    <= '0;
                    active_reg <= 1'b0;
                end else begin
                    row_reg    <= row_inc[CNT_W-1:0];
                    active_reg <= 1'b1;
                end
            end else begin
                col_reg    <= col_inc[CNT_W-1:0];
                row_reg    <= row_e;
                active_reg <= 1'b1;
            end
        end else if (cmd.color_load) begin
            color_reg <= grad_color;
        end
    end

    // Result register, loaded on each input transfer
    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            we_reg     <= active_e && visible;
            addr_reg   <= (active_e && visible) ? addr_full[ADDR_W-1:0] : '0;
            pcolor_reg <= active_e ? color_e : '0;
            done_reg   <= !active_e || pass_end;
        end
    end

    // Restoring divider lanes: product < 256*h, so the upper bits start as remainder
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_CH; i++) begin
            if (cmd.mul_load) begin
                rem_reg[i]  <= DIM_W'(ch_prod[i][PROD_W-1:CH_W]);
                low_reg[i]  <= ch_prod[i][CH_W-1:0];
                quot_reg[i] <= '0;
            end else if (cmd.div_step) begin
                rem_reg[i]  <= fits[i] ? DIM_W'(trial[i] - {1'b0, h_clamp})
                                       : trial[i][DIM_W-1:0];
                low_reg[i]  <= {low_reg[i][CH_W-2:0], 1'b0};
                quot_reg[i] <= {quot_reg[i][CH_W-2:0], fits[i]};
            end
        end
    end

    assign m_write_enable  = we_reg;
    assign m_pixel_address = addr_reg;
    assign m_pixel_color   = pcolor_reg;
    assign m_pass_done     = done_reg;

endmodule

// ===== src/grfr_ctrl.sv =====
// Controller: handshakes, result valid flag and the row color sequence
// (multiply, divide steps, commit). Depends on grfr_pkg.
module grfr_ctrl import grfr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;

    // Accept only when idle and the result register frees up
    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);

    assign cmd.take       = s_valid && s_ready;
    assign cmd.mul_load   = (state_reg == ST_MUL);
    assign cmd.div_step   = (state_reg == ST_DIV);
    assign cmd.color_load = (state_reg == ST_FIN);

    // Next state
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (cmd.take) begin
                    if (sts.row_adv) begin
                        state_next = ST_MUL;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_MUL: begin
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // A row change holds its result back until the new color is committed
    a_row_adv_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take && sts.row_adv |=> !m_valid_reg && (state_reg == ST_MUL))
        else $error("result shown before row color update");

    // The color commit presents the held result
    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.color_load |=> m_valid_reg && (state_reg == ST_IDLE))
        else $error("color commit did not present result");

    // No transfer in while a result would be overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.take |-> !m_valid_reg || m_ready)
        else $error("input accepted over a pending result");

    // Divide sequence runs its full length
    a_div_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> ($past(step_reg) == STEP_W'(DIV_STEPS - 1)))
        else $error("divider sequence cut short");

endmodule

// ===== sim/gradient_rect_fill_raster_top_tb.sv =====
// Self-checking testbench for gradient_rect_fill_raster_top: random valid/ready traffic,
// register rewrites between phases, and an in-bench pixel walk predictor.
// Depends on grfr_pkg and the gradient_rect_fill_raster_top RTL.
module gradient_rect_fill_raster_top_tb;
    import grfr_pkg::*;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               done;
    } pixel_result_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic                  s_restart = 1'b0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_write_enable;
    logic [ADDR_W-1:0]     m_pixel_address;
    logic [COLOR_W-1:0]    m_pixel_color;
    logic                  m_pass_done;

    gradient_rect_fill_raster_top u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_restart       (s_restart),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_write_enable  (m_write_enable),
        .m_pixel_address (m_pixel_address),
        .m_pixel_color   (m_pixel_color),
        .m_pass_done     (m_pass_done)
    );

    // Clock: period 10
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Predictor copy of the registers
    logic [DIM_W-1:0]   fb_cols, fb_rows, rect_left, rect_top, rect_width, rect_height;
    logic [COLOR_W-1:0] color_top, color_bottom;

    // Predictor copy of the walk state
    logic [CNT_W-1:0]   col_pos, row_pos;
    logic               in_pass;
    logic [COLOR_W-1:0] row_rgb;

    logic          restart_queue[$];
    pixel_result_t pixel_expect_q[$];
    int            items_queued = 0;
    int            items_taken  = 0;
    int            errors       = 0;
    logic          s_fire       = 1'b0;
    logic          gaps_on      = 1'b0;
    logic          stalls_on    = 1'b0;
    int            send_gap     = 0;
    int            stall_left   = 0;

    function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] v);
        return (v > 13'd4096) ? 13'd4096 : v;
    endfunction

    // One channel of the row blend, quotient truncated toward zero
    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                              input logic [CNT_W-1:0] row,
                                              input logic [DIM_W-1:0] h);
        logic [31:0] q;
        if (h == 0) return a;
        if (b >= a) begin
            q = (32'(b - a) * row) / h;
            return a + q[CH_W-1:0];
        end
        q = (32'(a - b) * row) / h;
        return a - q[CH_W-1:0];
    endfunction

    function automatic logic [COLOR_W-1:0] row_gradient(input logic [CNT_W-1:0] row);
        logic [DIM_W-1:0] h;
        h = limit_dim(rect_height);
        return {blend(color_top[23:16], color_bottom[23:16], row, h),
                blend(color_top[15:8],  color_bottom[15:8],  row, h),
                blend(color_top[7:0],   color_bottom[7:0],   row, h)};
    endfunction

    // Advance the walk by one pixel and return the expected result
    function automatic pixel_result_t walk_pixel(input logic restart);
        pixel_result_t    r;
        logic [DIM_W-1:0] w, h;
        logic [31:0]      px, py, lin;
        w = limit_dim(rect_width);
        h = limit_dim(rect_height);
        r = '0;
        if (restart) begin
            col_pos = '0;
            row_pos = '0;
            in_pass = (w != 0) && (h != 0);
            row_rgb = row_gradient('0);
        end
        if (!in_pass) begin
            r.done = 1'b1;
            return r;
        end
        // negative positions wrap to huge unsigned values and fail the compare
        px = {{19{rect_left[12]}}, rect_left} + 32'(col_pos);
        py = {{19{rect_top[12]}}, rect_top} + 32'(row_pos);
        lin = py * 32'(fb_cols) + px;
        r.we    = (px < 32'(fb_cols)) && (py < 32'(fb_rows));
        r.addr  = r.we ? lin[ADDR_W-1:0] : '0;
        r.color = row_rgb;
        if (32'(col_pos) + 1 >= 32'(w)) begin
            col_pos = '0;
            if (32'(row_pos) + 1 >= 32'(h)) begin
                r.done  = 1'b1;
                row_pos = '0;
                in_pass = 1'b0;
            end else begin
                row_pos = row_pos + 1'b1;
                row_rgb = row_gradient(row_pos);
            end
        end else begin
            col_pos = col_pos + 1'b1;
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10) $display("%s", msg);
    endtask

    // Input side: hold until transfer, then optional gap, then next item
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_fire) begin
            // item still waiting for ready
        end else if (send_gap > 0) begin
            s_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (restart_queue.size() != 0) begin
            s_restart <= restart_queue.pop_front();
            s_valid   <= 1'b1;
            send_gap  <= gaps_on ? pick_gap() : 0;
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Output side: random backpressure
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stalls_on && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= pick_gap();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Predict on input transfer, compare on output transfer
    always @(posedge aclk) begin : pixel_monitor
        pixel_result_t want;
        if (!aresetn) begin
            s_fire <= 1'b0;
        end else begin
            s_fire <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                pixel_expect_q.push_back(walk_pixel(s_restart));
                items_taken++;
            end
            if (m_valid && m_ready) begin
                if (pixel_expect_q.size() == 0) begin
                    flag_error($sformatf("unexpected pixel: we=%0d addr=%06h color=%06h done=%0d",
                        m_write_enable, m_pixel_address, m_pixel_color, m_pass_done));
                end else begin
                    want = pixel_expect_q.pop_front();
                    if (m_write_enable !== want.we || m_pixel_address !== want.addr ||
                        m_pixel_color !== want.color || m_pass_done !== want.done)
                        flag_error($sformatf(
                            "pixel mismatch: exp we=%0d addr=%06h color=%06h done=%0d, got we=%0d addr=%06h color=%06h done=%0d",
                            want.we, want.addr, want.color, want.done,
                            m_write_enable, m_pixel_address, m_pixel_color, m_pass_done));
                end
            end
        end
    end

    // Register write; dimension registers sometimes carry junk in the upper bits
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        logic [CFG_DATA_W-1:0] data;
        data = val;
        if (idx != REG_COLOR_TOP && idx != REG_COLOR_BOTTOM && $urandom_range(0, 1))
            data[23:13] = 11'($urandom);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_FB_COLS:      fb_cols      = data[12:0];
            REG_FB_ROWS:      fb_rows      = data[12:0];
            REG_RECT_LEFT:    rect_left    = data[12:0];
            REG_RECT_TOP:     rect_top     = data[12:0];
            REG_RECT_WIDTH:   rect_width   = data[12:0];
            REG_RECT_HEIGHT:  rect_height  = data[12:0];
            REG_COLOR_TOP:    color_top    = data;
            REG_COLOR_BOTTOM: color_bottom = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_item(input logic restart);
        restart_queue.push_back(restart);
        items_queued++;
    endtask

    // Wait until every item is taken and every result checked, then let the block settle
    task automatic wait_drain();
        while (items_taken != items_queued || pixel_expect_q.size() != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
    endtask

    // Random register value, weighted toward small rectangles and extremes
    function automatic logic [COLOR_W-1:0] reg_value(input logic [REG_IDX_W-1:0] idx);
        int r;
        r = $urandom_range(0, 19);
        case (idx)
            REG_FB_COLS, REG_FB_ROWS: begin
                if (r == 0) return 24'd0;
                if (r == 1) return 24'd4096;
                if (r == 2) return 24'd8191;
                return 24'($urandom_range(1, 16));
            end
            REG_RECT_LEFT, REG_RECT_TOP: begin
                if (r == 0) return 24'(13'h1000);
                if (r == 1) return 24'd4095;
                if (r == 2) return 24'(13'($urandom));
                return 24'(13'($urandom_range(0, 16)) - 13'd4);
            end
            REG_RECT_WIDTH, REG_RECT_HEIGHT: begin
                if (r == 0) return 24'd0;
                if (r == 1) return 24'd4096;
                if (r == 2) return 24'd8191;
                if (r == 3) return 24'd4097;
                return 24'($urandom_range(1, 6));
            end
            REG_COLOR_BOTTOM: begin
                // equal colors give a solid fill
                if (r < 4) return color_top;
                return 24'($urandom);
            end
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        int area, n_seq, n_mod, run;
        logic [REG_IDX_W-1:0] idx;
        logic continuing;

        fb_cols = '0; fb_rows = '0; rect_left = '0; rect_top = '0;
        rect_width = '0; rect_height = '0; color_top = '0; color_bottom = '0;
        col_pos = '0; row_pos = '0; in_pass = 1'b0; row_rgb = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Registers at reset: empty rectangle, restart stays idle
        queue_item(1'b1);
        queue_item(1'b0);
        wait_drain();

        // Full small pass with negative origin clipping and mixed-direction channels
        write_reg(REG_FB_COLS, 24'd8);
        write_reg(REG_FB_ROWS, 24'd8);
        write_reg(REG_RECT_LEFT, 24'(13'h1ffe));
        write_reg(REG_RECT_TOP, 24'(13'h1fff));
        write_reg(REG_RECT_WIDTH, 24'd4);
        write_reg(REG_RECT_HEIGHT, 24'd3);
        write_reg(REG_COLOR_TOP, 24'h00ff10);
        write_reg(REG_COLOR_BOTTOM, 24'hff0080);
        queue_item(1'b1);
        repeat (11) queue_item(1'b0);
        queue_item(1'b0);
        wait_drain();

        // Oversize dimensions and address wrap, then a restart mid-pass
        write_reg(REG_FB_COLS, 24'd8191);
        write_reg(REG_FB_ROWS, 24'd8191);
        write_reg(REG_RECT_LEFT, 24'd4095);
        write_reg(REG_RECT_TOP, 24'd4095);
        write_reg(REG_RECT_WIDTH, 24'd8191);
        write_reg(REG_RECT_HEIGHT, 24'd8191);
        write_reg(REG_COLOR_TOP, 24'hffffff);
        write_reg(REG_COLOR_BOTTOM, 24'h000000);
        queue_item(1'b1);
        queue_item(1'b0);
        queue_item(1'b0);
        queue_item(1'b1);
        queue_item(1'b0);
        wait_drain();

        // Height dropped to zero in the middle of a pass
        write_reg(REG_RECT_WIDTH, 24'd1);
        write_reg(REG_RECT_HEIGHT, 24'd4);
        queue_item(1'b1);
        queue_item(1'b0);
        wait_drain();
        write_reg(REG_RECT_HEIGHT, 24'd0);
        queue_item(1'b0);
        queue_item(1'b0);
        wait_drain();

        // Random phases
        while (items_queued < 920) begin
            gaps_on   = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            continuing = ($urandom_range(0, 9) < 3);
            if (continuing) begin
                // rewrite one or two registers and keep walking the current pass
                n_mod = $urandom_range(1, 2);
                repeat (n_mod) begin
                    idx = REG_IDX_W'($urandom);
                    write_reg(idx, reg_value(idx));
                end
                run = $urandom_range(1, 10);
                repeat (run) queue_item(1'b0);
            end else begin
                for (int i = REG_FB_COLS; i <= REG_COLOR_BOTTOM; i++)
                    write_reg(REG_IDX_W'(i), reg_value(REG_IDX_W'(i)));
            end
            n_seq = $urandom_range(1, 3);
            repeat (n_seq) begin
                area = int'(limit_dim(rect_width)) * int'(limit_dim(rect_height));
                if (area > 40) area = 40;
                if (area < 1) area = 1;
                queue_item($urandom_range(0, 9) != 0);
                repeat (area - 1) queue_item($urandom_range(0, 19) == 0);
                run = $urandom_range(0, 2);
                repeat (run) queue_item(1'b0);
            end
            wait_drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
src/grfr_pkg.sv
src/grfr_cfg_regs.sv
src/grfr_datapath.sv
src/grfr_ctrl.sv
src/gradient_rect_fill_raster_top.sv
sim/gradient_rect_fill_raster_top_tb.sv
